FILE: sv/tdf_pkg.sv
// Package for the TTL duplicate filter: payload structs, register indexes,
// defaults and the status struct between the sequencer and the top level.
// No dependencies.
package tdf_pkg;

    // Input transfer payload
    typedef struct packed {
        logic [63:0] msg_key;
        logic        key_empty;
        logic [31:0] now_secs;
    } tdf_in_t;

    // Output transfer payload
    typedef struct packed {
        logic        is_dup;
        logic [11:0] entries_used;
    } tdf_out_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } tdf_stat_t;

    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ENTRIES = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TTL_SECS    = 8'd1;

    localparam logic [10:0] DEFAULT_MAX = 11'd2000;
    localparam logic [15:0] DEFAULT_TTL = 16'd300;

endpackage

FILE: sv/tdf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tdf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: sv/tdf_seq.sv
// Sequencer of the TTL duplicate filter: scan, expire, append, compaction
// and shift passes over the entry RAM, one read and one write per cycle.
// Depends on tdf_pkg and tdf_ram.
module tdf_seq
    import tdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048,
    parameter int KEY_BITS    = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tdf_in_t     item,
    input  logic [10:0] max_entries,
    input  logic [15:0] ttl_secs,
    input  logic        res_take,
    output tdf_stat_t   stat,
    output tdf_out_t    res
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int WW = KEY_BITS + TIME_BITS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_LASTRD  = 3'd2;
    localparam logic [2:0] ST_LASTWR  = 3'd3;
    localparam logic [2:0] ST_APPEND  = 3'd4;
    localparam logic [2:0] ST_COMPACT = 3'd5;
    localparam logic [2:0] ST_SHIFT   = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        wr_reg, wr_next;
    logic [CW-1:0]        drop_reg, drop_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        paddr_reg, paddr_next;
    logic [AW-1:0]        mi_reg, mi_next;
    logic                 dup_reg, dup_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WW-1:0]        ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0]  rd_key;
    logic [TIME_BITS-1:0] rd_time;
    logic [TIME_BITS-1:0] ttl_t;
    logic [10:0]          max_m;
    logic [CW-1:0]        lim;
    logic                 rd_young;
    logic                 done_c;

    // entry RAM: key in the upper bits, last-seen time in the lower
    tdf_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[WW-1:TIME_BITS];
    assign rd_time = ram_rdata[TIME_BITS-1:0];

    // effective TTL and entry limit
    assign ttl_t = TIME_BITS'((ttl_secs != 16'd0) ? ttl_secs : DEFAULT_TTL);
    assign max_m = (max_entries != 11'd0) ? max_entries : DEFAULT_MAX;
    assign lim   = (32'(max_m) > 32'(TABLE_DEPTH - 1)) ? CW'(TABLE_DEPTH - 1)
                                                       : CW'(max_m);

    // young: time went backwards, or age below TTL
    assign rd_young = (now_reg < rd_time) || ((now_reg - rd_time) < ttl_t);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        drop_next  = drop_reg;
        pend_next  = 1'b0;
        paddr_next = paddr_reg;
        mi_next    = mi_reg;
        dup_next   = dup_reg;
        key_next   = key_reg;
        now_next   = now_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = {key_reg, now_reg};
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[AW-1:0];
        done_c     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = KEY_BITS'(item.msg_key);
                    now_next = TIME_BITS'(item.now_secs);
                    dup_next = 1'b0;
                    idx_next = '0;
                    state_next = item.key_empty ? ST_DONE : ST_SCAN;
                end
            end

            // pipelined key search, one entry per cycle
            ST_SCAN:
            begin
                if (pend_reg && (rd_key == key_reg))
                begin
                    if (rd_young)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = paddr_reg;
                        dup_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mi_next    = paddr_reg;
                        state_next = ST_LASTRD;
                    end
                end
                else if (idx_reg < cnt_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[AW-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_APPEND;
                end
            end

            // fetch the last entry to fill the expired slot
            ST_LASTRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(cnt_reg - 1'b1);
                state_next = ST_LASTWR;
            end

            ST_LASTWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = mi_reg;
                ram_wdata  = ram_rdata;
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_APPEND;
            end

            ST_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
                idx_next  = '0;
                wr_next   = '0;
                state_next = ((cnt_reg + 1'b1) > lim) ? ST_COMPACT : ST_DONE;
            end

            // keep young entries in order
            ST_COMPACT:
            begin
                if (pend_reg && rd_young)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (pend_reg && rd_young)
                begin
                    wr_next = wr_reg + 1'b1;
                end
                if (idx_reg < cnt_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    cnt_next = wr_reg;
                    if (wr_reg > lim)
                    begin
                        drop_next  = wr_reg - lim;
                        idx_next   = wr_reg - lim;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // drop the oldest positions
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(CW'(paddr_reg) - drop_reg);
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < cnt_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[AW-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    cnt_next   = lim;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    done_c     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat = '{busy: (state_reg != ST_IDLE), done: done_c};
    assign res  = '{is_dup: dup_reg, entries_used: 12'(cnt_reg)};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        wr_reg    <= wr_next;
        drop_reg  <= drop_next;
        paddr_reg <= paddr_next;
        mi_reg    <= mi_next;
        dup_reg   <= dup_next;
        key_reg   <= key_next;
        now_reg   <= now_next;
    end
endmodule

FILE: sv/ttl_duplicate_filter_top.sv
// Top level of the TTL duplicate filter: configuration registers, output
// register and the sequencer with its entry RAM.
// Depends on tdf_pkg and tdf_seq.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_stall | in_data  (tdf_in_t)
//  out     | output    | out_valid/out_stall | out_data (tdf_out_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. An empty id goes straight to its result; a hit or a plain
// append scans the stored entries, and an expiry and an append can trigger
// compaction and shift; the next transfer can follow in the cycle after the
// result. Each pass is bound by one RAM read a cycle.
// Reset clears the entry count; the RAM itself is never cleared.
// A finished result waits in the output register while the next item runs.
module ttl_duplicate_filter_top
    import tdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048,
    parameter int KEY_BITS    = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  tdf_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tdf_out_t                 out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);
    logic [10:0] max_reg;
    logic [15:0] ttl_reg;
    logic        out_valid_reg;
    tdf_out_t    out_reg;
    tdf_stat_t   stat;
    tdf_out_t    res;
    logic        res_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = stat.busy;
    assign res_take  = !out_valid_reg || !out_stall;

    tdf_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_valid && !in_stall),
        .item        (in_data),
        .max_entries (max_reg),
        .ttl_secs    (ttl_reg),
        .res_take    (res_take),
        .stat        (stat),
        .res         (res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= DEFAULT_MAX;
            ttl_reg <= DEFAULT_TTL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_ENTRIES)
            begin
                max_reg <= cfg_data[10:0];
            end
            else if (cfg_index == CFG_TTL_SECS)
            begin
                ttl_reg <= cfg_data;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

FILE: sv/tdf_checker.sv
// Port-level checker for the TTL duplicate filter, bound to the top level.
// Depends on tdf_pkg and ttl_duplicate_filter_top.
module tdf_checker
    import tdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048
) (
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input tdf_out_t out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("no stall after input transfer");

    // count stays below table depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.entries_used) < TABLE_DEPTH)
        else $error("entry count out of range");

    // a duplicate implies a stored entry
    a_dup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_dup |-> out_data.entries_used != 12'd0)
        else $error("duplicate with empty table");
endmodule

bind ttl_duplicate_filter_top tdf_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_tdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: bench/tb_top.sv
// Testbench for the TTL duplicate filter: directed and random key streams,
// checked against a behavioral table model held in this module.
// Depends on tdf_pkg and ttl_duplicate_filter_top.
module tb_top;
    import tdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 2048;
    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    tdf_in_t in_data;
    logic out_valid;
    logic out_stall;
    tdf_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Predictor state
    logic [63:0] tbl_key [DEPTH];
    logic [31:0] tbl_time [DEPTH];
    int unsigned tbl_count;
    logic [10:0] mdl_max;
    logic [15:0] mdl_ttl;
    tdf_out_t verdict_q[$];

    int err_count;
    int idle_cycles;
    bit stall_mode;
    logic [31:0] clock_s;
    logic [63:0] recent_keys[$];

    ttl_duplicate_filter_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit still_young(logic [31:0] t, logic [31:0] now, logic [15:0] ttl);
        if (now < t)
            return 1'b1;
        return (now - t) < {16'd0, ttl};
    endfunction

    // Table update for one item; returns the expected result
    function automatic tdf_out_t filter_item(tdf_in_t it);
        tdf_out_t r;
        logic [15:0] ttl;
        int unsigned lim;
        int unsigned w;
        int unsigned drop;
        bit found;
        bit dup;
        ttl = (mdl_ttl == 0) ? DEFAULT_TTL : mdl_ttl;
        dup = 1'b0;
        found = 1'b0;
        if (tbl_count > DEPTH - 1)
            tbl_count = DEPTH - 1;
        if (!it.key_empty) begin
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_key[i] == it.msg_key) begin
                    if (still_young(tbl_time[i], it.now_secs, ttl)) begin
                        tbl_time[i] = it.now_secs;
                        dup = 1'b1;
                        found = 1'b1;
                    end
                    else begin
                        tbl_key[i] = tbl_key[tbl_count-1];
                        tbl_time[i] = tbl_time[tbl_count-1];
                        tbl_count--;
                    end
                    break;
                end
            end
            if (!found) begin
                tbl_key[tbl_count] = it.msg_key;
                tbl_time[tbl_count] = it.now_secs;
                tbl_count++;
                lim = (mdl_max == 0) ? DEFAULT_MAX : mdl_max;
                if (lim > DEPTH - 1)
                    lim = DEPTH - 1;
                if (tbl_count > lim) begin
                    // keep young entries in order
                    w = 0;
                    for (int i = 0; i < tbl_count; i++) begin
                        if (still_young(tbl_time[i], it.now_secs, ttl)) begin
                            tbl_key[w] = tbl_key[i];
                            tbl_time[w] = tbl_time[i];
                            w++;
                        end
                    end
                    tbl_count = w;
                    // then drop the oldest positions
                    if (tbl_count > lim) begin
                        drop = tbl_count - lim;
                        for (int i = drop; i < tbl_count; i++) begin
                            tbl_key[i-drop] = tbl_key[i];
                            tbl_time[i-drop] = tbl_time[i];
                        end
                        tbl_count = lim;
                    end
                end
            end
        end
        r.is_dup = dup;
        r.entries_used = tbl_count[11:0];
        return r;
    endfunction

    // Send one item with a random burst gap
    task automatic send_item(logic [63:0] key, logic empty, logic [31:0] now);
        tdf_in_t it;
        it.msg_key = key;
        it.key_empty = empty;
        it.now_secs = now;
        @(posedge clk);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        verdict_q.push_back(filter_item(it));
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_ENTRIES)
            mdl_max = val[10:0];
        else if (idx == CFG_TTL_SECS)
            mdl_ttl = val;
    endtask

    // Field extremes, empty ids, hits, expiry, time going backwards
    task automatic test_directed();
        send_item(64'd0, 1'b0, 32'd0);
        send_item(64'd0, 1'b0, 32'd299);
        send_item(64'd0, 1'b0, 32'd599);
        send_item(64'd0, 1'b0, 32'd10);
        send_item({64{1'b1}}, 1'b0, {32{1'b1}});
        send_item({64{1'b1}}, 1'b0, 32'd5);
        send_item({64{1'b1}}, 1'b1, 32'd5);
        send_item(64'h5555_5555_5555_5555, 1'b0, 32'h5555_5555);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'hAAAA_AAAA);
        send_item(64'h5555_5555_5555_5555, 1'b0, 32'hAAAA_AAAA);
    endtask

    // Small tables so that compaction and dropping happen often
    task automatic test_prune();
        write_reg(CFG_MAX_ENTRIES, 16'd1);
        write_reg(CFG_TTL_SECS, 16'd1);
        send_item(64'd1, 1'b0, 32'd100);
        send_item(64'd2, 1'b0, 32'd100);
        send_item(64'd2, 1'b0, 32'd100);
        send_item(64'd3, 1'b0, 32'd101);
        write_reg(CFG_MAX_ENTRIES, 16'd3);
        write_reg(CFG_TTL_SECS, 16'd0);
        send_item(64'd4, 1'b0, 32'd200);
        send_item(64'd5, 1'b0, 32'd201);
        send_item(64'd6, 1'b0, 32'd202);
        send_item(64'd4, 1'b0, 32'd203);
        write_reg(CFG_MAX_ENTRIES, 16'd0);
        write_reg(CFG_TTL_SECS, 16'hFFFF);
        send_item(64'd7, 1'b0, 32'd0);
    endtask

    // Random key streams with repeats over a small key pool
    task automatic random_phase(int n, logic [10:0] maxe, logic [15:0] ttl);
        logic [63:0] k;
        write_reg(CFG_MAX_ENTRIES, {5'd0, maxe});
        write_reg(CFG_TTL_SECS, ttl);
        for (int i = 0; i < n; i++) begin
            if (recent_keys.size() != 0 && $urandom_range(0, 2) != 0)
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else begin
                k = {$urandom, $urandom};
                recent_keys.push_back(k);
                if (recent_keys.size() > 12)
                    void'(recent_keys.pop_front());
            end
            case ($urandom_range(0, 9))
                0: clock_s = {$urandom};
                1, 2: clock_s = clock_s - $urandom_range(0, 4);
                default: clock_s = clock_s + $urandom_range(0, 3);
            endcase
            send_item(k, ($urandom_range(0, 11) == 0), clock_s);
        end
    endtask

    task automatic test_random();
        clock_s = 32'd1000;
        random_phase(35, 11'd6, 16'd4);
        random_phase(25, 11'd2047, 16'd2);
        drain();
        random_phase(35, 11'd3, 16'd10);
        random_phase(25, 11'd1, 16'd65535);
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk) begin
        tdf_out_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    err_count++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (want.is_dup !== out_data.is_dup) begin
                        $display("%0t: is_dup expected %0d actual %0d", $time,
                            want.is_dup, out_data.is_dup);
                        err_count++;
                    end
                    if (want.entries_used !== out_data.entries_used) begin
                        $display("%0t: entries_used expected %0d actual %0d", $time,
                            want.entries_used, out_data.entries_used);
                        err_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 31) == 0)
                stall_mode <= ~stall_mode;
            out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        idle_cycles = 0;
        stall_mode = 1'b0;
        tbl_count = 0;
        mdl_max = DEFAULT_MAX;
        mdl_ttl = DEFAULT_TTL;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_prune();
        test_random();
        drain();
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
sv/tdf_pkg.sv
sv/tdf_ram.sv
sv/tdf_seq.sv
sv/ttl_duplicate_filter_top.sv
sv/tdf_checker.sv
bench/tb_top.sv
